/* rtl/core/rgb_rle_pkg.sv */
package rgb_rle_pkg;

  // Field widths of the pixel and packet streams.
  localparam int unsigned PIX_W = 24;
  localparam int unsigned HDR_W = 8;

  // Default longest packet, in pixels.
  localparam int unsigned MAX_PACKET_DEF = 32;

  // Run flag in the packet header.
  localparam logic [HDR_W-1:0] RUN_FLAG = HDR_W'(1 << 7);

  // Input item: one pixel and the end-of-image mark.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } rle_in_t;

  // Output item: either a packet header or one pixel of the packet.
  typedef struct packed {
    logic             is_header;
    logic [HDR_W-1:0] header;
    logic [PIX_W-1:0] pixel_out;
    logic             packet_end;
    logic             image_end;
  } rle_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LIT_WR,
    ST_RAW_HDR,
    ST_RAW_PIX,
    ST_RUN_HDR,
    ST_RUN_PIX
  } seq_state_t;

  // Operations that one pixel can queue, listed in the order they run.
  localparam int unsigned OP_RAW1  = 0;
  localparam int unsigned OP_RUN1  = 1;
  localparam int unsigned OP_WR2   = 2;
  localparam int unsigned OP_RAW2  = 3;
  localparam int unsigned OP_RUN2  = 4;
  localparam int unsigned NUM_OPS  = 5;

  typedef logic [NUM_OPS-1:0] op_set_t;

  // Strobes of the literal buffer.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

/* rtl/core/rgb_rle_lit_buf.sv */
module rgb_rle_lit_buf #(
  parameter int unsigned DEPTH = rgb_rle_pkg::MAX_PACKET_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  rgb_rle_pkg::ram_ctl_t          ctl,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [rgb_rle_pkg::PIX_W-1:0]  wr_data,
  input  logic [AW-1:0]                  rd_addr,
  output logic [rgb_rle_pkg::PIX_W-1:0]  rd_data
);
  import rgb_rle_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read strobe.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rgb_pixel_rle_packet_encoder_core.sv */
// Channel | Signals                    | Direction | Payload
// --------+----------------------------+-----------+------------------------------
// pix     | pix_valid, pix_ready, pix  | in        | pixel, last_pixel
// pkt     | pkt_valid, pkt_ready, pkt  | out       | header or pixel, packet marks
//
// A pixel that closes no packet passes the transfer, then the dispatch state. A
// raw packet adds a header and a pixel state per pixel, a run packet one of each;
// the literal buffer's single read port gives one entry per cycle unless pkt stalls.
// Reset is synchronous and clears all control state; the buffer needs no clearing.
// A stalled pkt channel holds the sequencer on the pending output transfer.
module rgb_pixel_rle_packet_encoder_core #(
  parameter int unsigned MAX_PACKET = rgb_rle_pkg::MAX_PACKET_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  rgb_rle_pkg::rle_in_t  pix,
  output logic                  pkt_valid,
  input  logic                  pkt_ready,
  output rgb_rle_pkg::rle_out_t pkt
);
  import rgb_rle_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PACKET + 1);
  localparam int unsigned AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_PACKET);
  localparam logic [CW-1:0] ONE  = CW'(1);

  // Encoder state.
  seq_state_t       state, state_next;
  op_set_t          pending, pending_next;
  logic [CW-1:0]    lit_count, lit_count_next;
  logic [PIX_W-1:0] held, held_next;
  logic [CW-1:0]    rep, rep_next;
  logic [PIX_W-1:0] run_pix, run_pix_next;
  logic [CW-1:0]    run_len, run_len_next;
  logic             img_last, img_last_next;
  logic [CW-1:0]    idx, idx_next;
  logic             out_valid, out_valid_next;
  rle_out_t         out_item, out_item_next;

  // Literal buffer port signals.
  ram_ctl_t         ram_ctl;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;

  // Main update of one accepted pixel.
  logic [PIX_W-1:0] m_held;
  logic [CW-1:0]    m_rep;
  logic [CW-1:0]    m_lit;
  logic [CW-1:0]    m_lit_after;
  logic             m_wr;
  op_set_t          m_plan;
  logic [PIX_W-1:0] m_run_pix;
  logic [CW-1:0]    m_run_len;
  logic [CW-1:0]    rep_inc;
  logic [CW-1:0]    lit_inc;
  logic [CW-1:0]    idx_inc;
  logic             load_ok;
  logic             raw_final;

  assign rep_inc   = rep + ONE;
  assign lit_inc   = lit_count + ONE;
  assign idx_inc   = idx + ONE;
  assign load_ok   = !out_valid || pkt_ready;
  assign raw_final = (idx_inc == lit_count);

  assign pkt_valid = out_valid;
  assign pkt       = out_item;

  // Greedy run/literal decision, then the flush plan for the image's last pixel.
  always_comb begin
    m_held    = held;
    m_rep     = rep;
    m_lit     = lit_count;
    m_wr      = 1'b0;
    m_plan    = '0;
    m_run_pix = held;
    m_run_len = rep;
    if (rep == '0) begin
      m_held = pix.pixel;
      m_rep  = ONE;
    end else if (pix.pixel == held) begin
      m_plan[OP_RAW1] = (rep == ONE) && (lit_count != '0);
      m_rep = rep_inc;
      if (rep_inc >= MAXC) begin
        m_plan[OP_RUN1] = 1'b1;
        m_run_len       = rep_inc;
        m_rep           = '0;
      end
    end else begin
      if (rep == ONE) begin
        m_wr            = 1'b1;
        m_lit           = lit_inc;
        m_plan[OP_RAW1] = (lit_inc >= MAXC);
      end else begin
        m_plan[OP_RUN1] = 1'b1;
      end
      m_held = pix.pixel;
      m_rep  = ONE;
    end

    m_lit_after = m_plan[OP_RAW1] ? '0 : m_lit;
    if (pix.last_pixel) begin
      m_plan[OP_WR2]  = (m_rep == ONE);
      m_plan[OP_RAW2] = (m_rep == ONE) || (m_lit_after != '0);
      m_plan[OP_RUN2] = (m_rep >= CW'(2));
    end
    if (!m_plan[OP_RUN1]) begin
      m_run_pix = m_held;
      m_run_len = m_rep;
    end
  end

  // Sequencer: next state, buffer strobes and the output register load.
  always_comb begin
    state_next     = state;
    pending_next   = pending;
    lit_count_next = lit_count;
    held_next      = held;
    rep_next       = rep;
    run_pix_next   = run_pix;
    run_len_next   = run_len;
    img_last_next  = img_last;
    idx_next       = idx;
    out_valid_next = out_valid && !pkt_ready;
    out_item_next  = out_item;
    ram_ctl        = '0;
    rd_addr        = '0;
    pix_ready      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          ram_ctl.wr_en  = m_wr;
          held_next      = m_held;
          rep_next       = m_rep;
          lit_count_next = m_lit;
          pending_next   = m_plan;
          run_pix_next   = m_run_pix;
          run_len_next   = m_run_len;
          img_last_next  = pix.last_pixel;
          state_next     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        idx_next = '0;
        priority if (pending[OP_RAW1]) begin
          pending_next[OP_RAW1] = 1'b0;
          state_next = ST_RAW_HDR;
        end else if (pending[OP_RUN1]) begin
          pending_next[OP_RUN1] = 1'b0;
          state_next = ST_RUN_HDR;
        end else if (pending[OP_WR2]) begin
          pending_next[OP_WR2] = 1'b0;
          state_next = ST_LIT_WR;
        end else if (pending[OP_RAW2]) begin
          pending_next[OP_RAW2] = 1'b0;
          state_next = ST_RAW_HDR;
        end else if (pending[OP_RUN2]) begin
          pending_next[OP_RUN2] = 1'b0;
          state_next = ST_RUN_HDR;
        end else begin
          // All packets out; the end of an image returns to the reset state.
          if (img_last) begin
            lit_count_next = '0;
            held_next      = '0;
            rep_next       = '0;
            img_last_next  = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end
      ST_LIT_WR: begin
        ram_ctl.wr_en  = 1'b1;
        lit_count_next = lit_inc;
        state_next     = ST_DISPATCH;
      end
      ST_RAW_HDR: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_item_next  = '{is_header: 1'b1,
                            header: HDR_W'(lit_count - ONE),
                            pixel_out: '0, packet_end: 1'b0, image_end: 1'b0};
          ram_ctl.rd_en  = 1'b1;
          rd_addr        = '0;
          state_next     = ST_RAW_PIX;
        end
      end
      ST_RAW_PIX: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_item_next  = '{is_header: 1'b0, header: '0, pixel_out: rd_data,
                            packet_end: raw_final,
                            image_end: raw_final && img_last && (pending == '0)};
          if (raw_final) begin
            lit_count_next = '0;
            state_next     = ST_DISPATCH;
          end else begin
            idx_next      = idx_inc;
            ram_ctl.rd_en = 1'b1;
            rd_addr       = idx_inc[AW-1:0];
          end
        end
      end
      ST_RUN_HDR: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_item_next  = '{is_header: 1'b1,
                            header: RUN_FLAG | HDR_W'(run_len - ONE),
                            pixel_out: '0, packet_end: 1'b0, image_end: 1'b0};
          state_next     = ST_RUN_PIX;
        end
      end
      ST_RUN_PIX: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_item_next  = '{is_header: 1'b0, header: '0, pixel_out: run_pix,
                            packet_end: 1'b1,
                            image_end: img_last && (pending == '0)};
          state_next     = ST_DISPATCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      lit_count <= '0;
      held      <= '0;
      rep       <= '0;
      img_last  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      lit_count <= lit_count_next;
      held      <= held_next;
      rep       <= rep_next;
      img_last  <= img_last_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run_pix  <= run_pix_next;
    run_len  <= run_len_next;
    idx      <= idx_next;
    out_item <= out_item_next;
  end

  // Pending literal pixels.
  rgb_rle_lit_buf #(
    .DEPTH(MAX_PACKET)
  ) u_lit_buf (
    .clk    (clk),
    .ctl    (ram_ctl),
    .wr_addr(lit_count[AW-1:0]),
    .wr_data(held),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The literal count never passes the packet limit.
  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    lit_count <= MAXC)
    else $error("literal count exceeds the packet limit");

  // Between pixels a held repeat is always shorter than a full packet.
  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (rep < MAXC))
    else $error("full run left pending between pixels");

  // A raw packet never starts with an empty buffer.
  a_raw_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RAW_HDR) |-> (lit_count != '0))
    else $error("raw packet with no literals");

  // Waiting for a pixel means all queued work and any image end are done.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((pending == '0) && !img_last))
    else $error("work left over while idle");

  // A new pixel is taken only from the idle state and always leads to dispatch.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |=> (state == ST_DISPATCH))
    else $error("pixel transfer did not start dispatch");

endmodule
